// ===== design/mic_pkg.sv =====
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants of the magnetometer iron calibration core.
// ----------------------------------------------------------------------------
package mic_pkg;

	// fixed widths of the register and result fields
	localparam int COEF_W      = 16;
	localparam int OFFSET_W    = 16;
	localparam int RESULT_W    = 16;
	localparam int CROSS_W     = 48;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;

	// offset-corrected sample: 16-bit sample minus 16-bit offset, full width
	localparam int DIFF_W = OFFSET_W + 1;
	localparam int PROD_W = DIFF_W + COEF_W;
	// three products summed
	localparam int ACC_W  = PROD_W + 2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Z    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DIAG_XX     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DIAG_YY     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DIAG_ZZ     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CROSS_TERMS = 3'd6;

	// reset value of the diagonal: 1.0 in Q2.14
	localparam logic signed [COEF_W-1:0] DIAG_RESET = 16'sd16384;

	typedef struct packed {
		logic [7:0] x_low;
		logic [7:0] x_high;
		logic [7:0] y_low;
		logic [7:0] y_high;
		logic [7:0] z_low;
		logic [7:0] z_high;
	} sample_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] field_x;
		logic signed [RESULT_W-1:0] field_y;
		logic signed [RESULT_W-1:0] field_z;
		logic                       clipped;
	} field_t;

	// one lane's finished axis
	typedef struct packed {
		logic signed [RESULT_W-1:0] value;
		logic                       clip;
	} lane_res_t;

endpackage

// ===== design/magnetometer_iron_calibration_core.sv =====
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration_core
// Hard-iron offset and soft-iron matrix calibration of magnetometer samples.
// ----------------------------------------------------------------------------
// Takes one six-byte magnetometer read per clock while sample_stall is low
// and returns one calibrated x/y/z beat per read, in order. A beat passes
// the difference, product, lane result and output registers; the sustained
// rate is one read per cycle while the output is not stalled, set by three
// row lanes that each hold their own three multipliers and work in step.
// The output side has a register and a one-beat skid, so sample_stall is a
// registered signal and the input keeps flowing while a finished beat waits.
// The x result is negated after rounding; any axis that saturates sets
// clipped. Registers are written through cfg_write/cfg_index/cfg_data and
// must only be changed while the block is idle.
module magnetometer_iron_calibration_core import mic_pkg::*; #(
	parameter int COEF_FRAC_BITS = 14,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  sample_t                sample,
	output logic                   field_valid,
	input  logic                   field_stall,
	output field_t                 field
);

	logic signed [OFFSET_W-1:0] offset_q [3];
	logic signed [COEF_W-1:0]   diag_q [3];
	logic [CROSS_W-1:0]         cross_q;

	logic signed [COEF_W-1:0] cxy, cxz, cyz;
	logic [15:0]              raw [3];
	logic signed [DIFF_W-1:0] diff [3];
	logic signed [DIFF_W-1:0] d_s1 [3];
	logic                     valid_s1, valid_s2, valid_s3;
	logic                     hold;
	logic                     en;
	lane_res_t                res_x, res_y, res_z;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				offset_q[i] <= '0;
				diag_q[i]   <= DIAG_RESET;
			end
			cross_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_OFFSET_X:    offset_q[0] <= cfg_data[OFFSET_W-1:0];
				REG_OFFSET_Y:    offset_q[1] <= cfg_data[OFFSET_W-1:0];
				REG_OFFSET_Z:    offset_q[2] <= cfg_data[OFFSET_W-1:0];
				REG_DIAG_XX:     diag_q[0]   <= cfg_data[COEF_W-1:0];
				REG_DIAG_YY:     diag_q[1]   <= cfg_data[COEF_W-1:0];
				REG_DIAG_ZZ:     diag_q[2]   <= cfg_data[COEF_W-1:0];
				REG_CROSS_TERMS: cross_q     <= cfg_data[CROSS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cxy = cross_q[COEF_W-1:0];
	assign cxz = cross_q[2*COEF_W-1:COEF_W];
	assign cyz = cross_q[3*COEF_W-1:2*COEF_W];

	assign en           = ~hold;
	assign sample_stall = hold;

	// little-endian byte join, sign taken at SAMPLE_BITS, offset removed
	assign raw[0] = {sample.x_high, sample.x_low};
	assign raw[1] = {sample.y_high, sample.y_low};
	assign raw[2] = {sample.z_high, sample.z_low};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = signed'({{(DIFF_W - SAMPLE_BITS){raw[i][SAMPLE_BITS-1]}},
				raw[i][SAMPLE_BITS-1:0]})
				- signed'({offset_q[i][OFFSET_W-1], offset_q[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= diff[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= sample_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// x row, negated for board orientation
	mic_lane #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.NEGATE        (1'b1)
	) u_lane_x (
		.clk(clk), .en(en),
		.d0(d_s1[0]), .d1(d_s1[1]), .d2(d_s1[2]),
		.c0(diag_q[0]), .c1(cxy), .c2(cxz),
		.res(res_x)
	);

	mic_lane #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.NEGATE        (1'b0)
	) u_lane_y (
		.clk(clk), .en(en),
		.d0(d_s1[0]), .d1(d_s1[1]), .d2(d_s1[2]),
		.c0(cxy), .c1(diag_q[1]), .c2(cyz),
		.res(res_y)
	);

	mic_lane #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.NEGATE        (1'b0)
	) u_lane_z (
		.clk(clk), .en(en),
		.d0(d_s1[0]), .d1(d_s1[1]), .d2(d_s1[2]),
		.c0(cxz), .c1(cyz), .c2(diag_q[2]),
		.res(res_z)
	);

	mic_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (valid_s3),
		.res_x      (res_x),
		.res_y      (res_y),
		.res_z      (res_z),
		.field_stall(field_stall),
		.field_valid(field_valid),
		.field      (field),
		.hold       (hold)
	);

endmodule

// ===== design/mic_lane.sv =====
// ----------------------------------------------------------------------------
// mic_lane
// One matrix row: three products, sum, round, optional negate, saturate.
// ----------------------------------------------------------------------------
module mic_lane import mic_pkg::*; #(
	parameter int COEF_FRAC_BITS = 14,
	parameter bit NEGATE         = 1'b0
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DIFF_W-1:0] d0,
	input  logic signed [DIFF_W-1:0] d1,
	input  logic signed [DIFF_W-1:0] d2,
	input  logic signed [COEF_W-1:0] c0,
	input  logic signed [COEF_W-1:0] c1,
	input  logic signed [COEF_W-1:0] c2,
	output lane_res_t                res
);

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX    = (ACC_W'(1) << (RESULT_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_MIN    = -(ACC_W'(1) << (RESULT_W - 1));

	logic signed [PROD_W-1:0] p0_s2, p1_s2, p2_s2;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  val;
	lane_res_t                res_d;
	lane_res_t                res_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2 <= d0 * c0;
			p1_s2 <= d1 * c1;
			p2_s2 <= d2 * c2;
		end
	end

	always_comb begin
		acc = ACC_W'(p0_s2) + ACC_W'(p1_s2) + ACC_W'(p2_s2);
		// round to nearest, halves up
		rnd = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
		val = NEGATE ? -rnd : rnd;
		if (val > SAT_MAX) begin
			res_d.value = SAT_MAX[RESULT_W-1:0];
			res_d.clip  = 1'b1;
		end else if (val < SAT_MIN) begin
			res_d.value = SAT_MIN[RESULT_W-1:0];
			res_d.clip  = 1'b1;
		end else begin
			res_d.value = val[RESULT_W-1:0];
			res_d.clip  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_d;
		end
	end

	assign res = res_s3;

endmodule

// ===== design/mic_merge.sv =====
// ----------------------------------------------------------------------------
// mic_merge
// Joins the three lane results into one beat, with output register and skid.
// ----------------------------------------------------------------------------
module mic_merge import mic_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	input  lane_res_t res_x,
	input  lane_res_t res_y,
	input  lane_res_t res_z,
	input  logic      field_stall,
	output logic      field_valid,
	output field_t    field,
	output logic      hold
);

	field_t merged;
	field_t out_q;
	field_t skid_q;
	logic   out_valid_q;
	logic   skid_valid_q;
	logic   take;
	logic   out_free;

	always_comb begin
		merged.field_x = res_x.value;
		merged.field_y = res_y.value;
		merged.field_z = res_z.value;
		merged.clipped = res_x.clip | res_y.clip | res_z.clip;
	end

	assign take     = res_valid & ~skid_valid_q;
	assign out_free = ~out_valid_q | ~field_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			// output stalled: park the beat
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : merged;
		end else if (take) begin
			skid_q <= merged;
		end
	end

	assign field_valid = out_valid_q;
	assign field       = out_q;
	assign hold        = skid_valid_q;

endmodule

// ===== bench/mic_field_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_field_checker
// Watches the sample and field channels of the iron calibration core, keeps
// its own copy of the calibration registers, works out the calibrated field
// of every accepted sample and compares it with the beats that come out.
// ----------------------------------------------------------------------------
module mic_field_checker import mic_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   sample_valid,
	input  logic                   sample_stall,
	input  sample_t                sample,
	input  logic                   field_valid,
	input  logic                   field_stall,
	input  field_t                 field,
	output int                     fail_count,
	output int                     pending,
	output int                     beats_checked
);

	localparam int     FRAC_BITS = 14;
	localparam longint RES_MAX   = 32767;
	localparam longint RES_MIN   = -32768;

	logic signed [OFFSET_W-1:0] off_x, off_y, off_z;
	logic signed [COEF_W-1:0]   diag_xx, diag_yy, diag_zz;
	logic [CROSS_W-1:0]         cross_coef;

	field_t expected_fields[$];

	// round to nearest, halves toward plus infinity
	function automatic longint round_q(longint acc);
		return (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic bit out_of_range(longint v);
		return (v > RES_MAX) || (v < RES_MIN);
	endfunction

	function automatic logic signed [RESULT_W-1:0] clamp16(longint v);
		if (v > RES_MAX) begin
			return RESULT_W'(RES_MAX);
		end
		if (v < RES_MIN) begin
			return RESULT_W'(RES_MIN);
		end
		return v[RESULT_W-1:0];
	endfunction

	function automatic field_t calibrate(sample_t s);
		longint dx, dy, dz, kxy, kxz, kyz, rx, ry, rz;
		field_t res;
		// offset subtraction at full width, never saturated
		dx = longint'($signed({s.x_high, s.x_low})) - longint'(off_x);
		dy = longint'($signed({s.y_high, s.y_low})) - longint'(off_y);
		dz = longint'($signed({s.z_high, s.z_low})) - longint'(off_z);
		kxy = longint'($signed(cross_coef[15:0]));
		kxz = longint'($signed(cross_coef[31:16]));
		kyz = longint'($signed(cross_coef[47:32]));
		// x is negated after rounding, so -32768 becomes a clip
		rx = -round_q(longint'(diag_xx) * dx + kxy * dy + kxz * dz);
		ry = round_q(kxy * dx + longint'(diag_yy) * dy + kyz * dz);
		rz = round_q(kxz * dx + kyz * dy + longint'(diag_zz) * dz);
		res.field_x = clamp16(rx);
		res.field_y = clamp16(ry);
		res.field_z = clamp16(rz);
		res.clipped = out_of_range(rx) | out_of_range(ry) | out_of_range(rz);
		return res;
	endfunction

	function automatic int mismatch(string name, logic signed [16:0] want,
			logic signed [16:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		field_t want;
		int     errs;
		if (!arst_n) begin
			off_x         = '0;
			off_y         = '0;
			off_z         = '0;
			diag_xx       = DIAG_RESET;
			diag_yy       = DIAG_RESET;
			diag_zz       = DIAG_RESET;
			cross_coef    = '0;
			fail_count    <= 0;
			pending       <= 0;
			beats_checked <= 0;
			expected_fields.delete();
		end else begin
			errs = 0;
			if (field_valid && !field_stall) begin
				if (expected_fields.size() == 0) begin
					$error("field beat with nothing expected: %h", field);
					errs++;
				end else begin
					want = expected_fields.pop_front();
					errs += mismatch("field_x", want.field_x, field.field_x);
					errs += mismatch("field_y", want.field_y, field.field_y);
					errs += mismatch("field_z", want.field_z, field.field_z);
					errs += mismatch("clipped", want.clipped, field.clipped);
				end
				beats_checked <= beats_checked + 1;
			end
			if (sample_valid && !sample_stall) begin
				expected_fields.push_back(calibrate(sample));
			end
			// registers change only while idle, after any sample of this edge
			if (cfg_write) begin
				case (cfg_index)
					REG_OFFSET_X:    off_x = cfg_data[OFFSET_W-1:0];
					REG_OFFSET_Y:    off_y = cfg_data[OFFSET_W-1:0];
					REG_OFFSET_Z:    off_z = cfg_data[OFFSET_W-1:0];
					REG_DIAG_XX:     diag_xx = cfg_data[COEF_W-1:0];
					REG_DIAG_YY:     diag_yy = cfg_data[COEF_W-1:0];
					REG_DIAG_ZZ:     diag_zz = cfg_data[COEF_W-1:0];
					REG_CROSS_TERMS: cross_coef = cfg_data[CROSS_W-1:0];
					default: ;
				endcase
			end
			fail_count <= fail_count + errs;
			pending    <= expected_fields.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the magnetometer iron calibration core: directed
// samples at the field extremes, rounding halves, offset and coefficient corner cases,
// then random samples under a series of register settings, with random
// gaps and output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import mic_pkg::*;

	typedef enum int {STYLE_NOMINAL, STYLE_FULL, STYLE_EXTREME} style_t;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
	localparam int NUM_INDEXES  = 2 ** CFG_INDEX_W;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 400;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 120;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_write    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	sample_t                sample       = '0;
	logic                   field_valid;
	logic                   field_stall  = 1'b0;
	field_t                 field;

	int fail_count, pending, beats_checked;
	int gap_max       = 0;
	int stall_max     = 0;
	bit long_hold_req = 1'b0;
	int items_sent    = 0;
	int settings_used = 0;

	logic [CFG_DATA_W-1:0] reg_val [NUM_INDEXES];

	always #5 clk = ~clk;

	magnetometer_iron_calibration_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.field_valid  (field_valid),
		.field_stall  (field_stall),
		.field        (field)
	);

	mic_field_checker u_field_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.field_valid   (field_valid),
		.field_stall   (field_stall),
		.field         (field),
		.fail_count    (fail_count),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	function automatic logic [15:0] draw16(style_t style, int centre);
		case (style)
			STYLE_NOMINAL: return 16'(centre + $urandom_range(0, 4000) - 2000);
			STYLE_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					3: return 16'hffff;
					default: return 16'h0001;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t make_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		sample_t s;
		s.x_low  = x[7:0];
		s.x_high = x[15:8];
		s.y_low  = y[7:0];
		s.y_high = y[15:8];
		s.z_low  = z[7:0];
		s.z_high = z[15:8];
		return s;
	endfunction

	function automatic logic [15:0] draw_axis(style_t style);
		// a corner value now and then on top of the style's spread
		if ($urandom_range(0, 7) == 0) begin
			return draw16(STYLE_EXTREME, 0);
		end
		return draw16(style, 0);
	endfunction

	task automatic offer(input sample_t s);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (sample_stall);
		items_sent++;
	endtask

	// stop offering and wait until every expected beat is back
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting();
		for (int i = 0; i < NUM_INDEXES; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data  <= reg_val[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic load_setting(input int ox, input int oy, input int oz, input int xx,
			input int yy, input int zz, input int xy, input int xz, input int yz);
		reg_val[REG_OFFSET_X]    = {32'd0, 16'(ox)};
		reg_val[REG_OFFSET_Y]    = {32'd0, 16'(oy)};
		reg_val[REG_OFFSET_Z]    = {32'd0, 16'(oz)};
		reg_val[REG_DIAG_XX]     = {32'd0, 16'(xx)};
		reg_val[REG_DIAG_YY]     = {32'd0, 16'(yy)};
		reg_val[REG_DIAG_ZZ]     = {32'd0, 16'(zz)};
		reg_val[REG_CROSS_TERMS] = {16'(yz), 16'(xz), 16'(xy)};
		reg_val[REG_SPARE]       = {$urandom, 16'($urandom)};
		apply_setting();
	endtask

	task automatic random_setting(input style_t style);
		// upper bits of the 16-bit registers carry noise
		reg_val[REG_OFFSET_X]    = {$urandom, draw16(style, 0)};
		reg_val[REG_OFFSET_Y]    = {$urandom, draw16(style, 0)};
		reg_val[REG_OFFSET_Z]    = {$urandom, draw16(style, 0)};
		reg_val[REG_DIAG_XX]     = {$urandom, draw16(style, 16384)};
		reg_val[REG_DIAG_YY]     = {$urandom, draw16(style, 16384)};
		reg_val[REG_DIAG_ZZ]     = {$urandom, draw16(style, 16384)};
		reg_val[REG_CROSS_TERMS] = {draw16(style, 0), draw16(style, 0), draw16(style, 0)};
		reg_val[REG_SPARE]       = {$urandom, 16'($urandom)};
		apply_setting();
	endtask

	// output side: random stall per beat, one long hold-off on request
	initial begin : field_side
		int hold;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else begin
				hold = $urandom_range(0, stall_max);
			end
			if (hold > 0) begin
				field_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			field_stall <= 1'b0;
			do @(posedge clk); while (!field_valid);
		end
	end

	initial begin : stimulus
		style_t style;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: identity matrix, no offsets
		offer(make_sample(16'h0000, 16'h0000, 16'h0000));
		offer(make_sample(16'h7fff, 16'h7fff, 16'h7fff));
		offer(make_sample(16'h8000, 16'h8000, 16'h8000));
		offer(make_sample(16'hffff, 16'hffff, 16'hffff));
		offer(make_sample(16'h0001, 16'hff80, 16'h1234));
		offer(make_sample(16'h00ff, 16'hff00, 16'h5aa5));
		drain();

		// smallest diagonal: results are the samples over 2^14, x negated, rounding halves
		load_setting(0, 0, 0, 1, 1, 1, 0, 0, 0);
		offer(make_sample(16'd8192, -16'sd8192, 16'd8191));
		offer(make_sample(-16'sd8193, 16'd24576, -16'sd24576));
		drain();

		// offset extremes give 17-bit differences; x lands on -32768 unclipped
		load_setting(-32768, 32767, -32768, 8192, 8192, 8192, 0, 0, 0);
		offer(make_sample(16'h7fff, 16'h8000, 16'h8000));
		offer(make_sample(16'h8000, 16'h7fff, 16'h7fff));
		offer(make_sample(16'h0000, 16'h0000, 16'h0000));
		drain();

		// coefficient extremes on diagonal and cross terms
		load_setting(0, 0, 0, -32768, 32767, -32768, -1, -32768, 32767);
		offer(make_sample(16'h7fff, 16'h7fff, 16'h7fff));
		offer(make_sample(16'h8000, 16'h8000, 16'h8000));
		offer(make_sample(16'h0001, 16'hffff, 16'h0000));
		offer(make_sample(16'h0000, 16'h0000, 16'h0000));
		offer(make_sample(16'h0002, 16'h8000, 16'h7fff));
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			style = style_t'(phase % 3);
			case (phase % 4)
				0: begin
					gap_max   = 0;
					stall_max = 0;
				end
				1: begin
					gap_max   = 14;
					stall_max = 14;
				end
				2: begin
					gap_max   = 0;
					stall_max = 14;
				end
				default: begin
					gap_max   = $urandom_range(0, 14);
					stall_max = $urandom_range(0, 14);
				end
			endcase
			random_setting(style);
			if (phase == 2) begin
				// back-to-back beats against a long output hold-off
				gap_max       = 0;
				long_hold_req = 1'b1;
				for (int k = 0; k < 60; k++) offer(make_sample(draw_axis(style),
					draw_axis(style), draw_axis(style)));
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				offer(make_sample(draw_axis(style), draw_axis(style), draw_axis(style)));
			end
			drain();
		end

		$display("covered %0d samples under %0d register settings, %0d field beats checked",
			items_sent, settings_used, beats_checked);
		$display("includes rounding halves, x negation clip, offset and coefficient extremes");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("timeout waiting for the calibration core");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== magnetometer_iron_calibration_core.f =====
design/mic_pkg.sv
design/mic_lane.sv
design/mic_merge.sv
design/magnetometer_iron_calibration_core.sv
bench/mic_field_checker.sv
bench/tb_top.sv
